@@ hw/rtl/bfmd_pkg.sv @@
`timescale 1ns / 1ps

package bfmd_pkg;

    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_DEPTH    = 256;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam int NUM_CHAN  = 4;
    localparam int CHAN_W    = 8;
    localparam int SUM_W     = 11;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CH_CNT_W  = 3;

    localparam int OUTQ_DEPTH = 3;
    localparam int QPTR_W     = $clog2(OUTQ_DEPTH);
    localparam int QCNT_W     = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_SRC_DEPTH,
        CFG_CHANNELS
    } t_cfg_reg;

    typedef struct packed {
        logic in_range;
        logic even;
        logic last_smp;
        logic last_blk;
        logic at_end;
        logic multi;
    } t_axis_flags;

    typedef struct packed {
        logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
        logic                            last;
    } t_px_out;

endpackage

@@ hw/rtl/bfmd_src_if.sv @@
`timescale 1ns / 1ps

interface bfmd_src_if;
    logic                       valid;
    logic                       ready;
    logic [bfmd_pkg::CHAN_W-1:0] chan0_in;
    logic [bfmd_pkg::CHAN_W-1:0] chan1_in;
    logic [bfmd_pkg::CHAN_W-1:0] chan2_in;
    logic [bfmd_pkg::CHAN_W-1:0] chan3_in;

    modport source (output valid, chan0_in, chan1_in, chan2_in, chan3_in, input ready);
    modport sink   (input valid, chan0_in, chan1_in, chan2_in, chan3_in, output ready);
endinterface

@@ hw/rtl/bfmd_dst_if.sv @@
`timescale 1ns / 1ps

interface bfmd_dst_if;
    logic                       valid;
    logic                       ready;
    logic [bfmd_pkg::CHAN_W-1:0] chan0_out;
    logic [bfmd_pkg::CHAN_W-1:0] chan1_out;
    logic [bfmd_pkg::CHAN_W-1:0] chan2_out;
    logic [bfmd_pkg::CHAN_W-1:0] chan3_out;
    logic                       last_of_level;

    modport source (output valid, chan0_out, chan1_out, chan2_out, chan3_out,
                    last_of_level, input ready);
    modport sink   (input valid, chan0_out, chan1_out, chan2_out, chan3_out,
                    last_of_level, output ready);
endinterface

@@ hw/rtl/bfmd_axis.sv @@
`timescale 1ns / 1ps

module bfmd_axis #(
    parameter int MAX_SIZE = bfmd_pkg::DEF_MAX_WIDTH,
    localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_step,
    input  logic [bfmd_pkg::CFG_W-1:0]    i_cfg_size,
    output logic [CW-1:0]                 o_pos,
    output logic [CW:0]                   o_half,
    output bfmd_pkg::t_axis_flags         o_flags
);
    localparam int KW = (CW + 1 > bfmd_pkg::CFG_W) ? CW + 1 : bfmd_pkg::CFG_W;

    logic [CW-1:0] r_pos;
    logic [CW-1:0] n_pos;
    logic [KW-1:0] cfg_k;
    logic [KW-1:0] size_k;
    logic [CW:0]   size;
    logic [CW:0]   half_raw;
    logic [CW:0]   half;

    always_comb begin
        cfg_k = KW'(i_cfg_size);
        if (cfg_k == '0) begin
            size_k = KW'(1);
        end else if (cfg_k > KW'(MAX_SIZE)) begin
            size_k = KW'(MAX_SIZE);
        end else begin
            size_k = cfg_k;
        end
        size     = size_k[CW:0];
        half_raw = size >> 1;
        half     = (half_raw == '0) ? (CW+1)'(1) : half_raw;
    end

    always_comb begin
        o_flags.in_range = (CW+2)'(r_pos) < {half, 1'b0};
        o_flags.even     = ~r_pos[0];
        o_flags.multi    = size != (CW+1)'(1);
        o_flags.last_smp = o_flags.multi ? r_pos[0] : 1'b1;
        o_flags.last_blk = (CW+1)'(r_pos >> 1) == (half - 1'b1);
        o_flags.at_end   = ((CW+1)'(r_pos) + 1'b1) >= size;
    end

    always_comb begin
        n_pos = r_pos;
        if (i_clear) begin
            n_pos = '0;
        end else if (i_step) begin
            n_pos = o_flags.at_end ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_pos  = r_pos;
    assign o_half = half;

endmodule

@@ hw/rtl/box_filter_mip_downsampler_core.sv @@
`timescale 1ns / 1ps

// 2x2x2 box-filter mip downsampler.
// i_src carries one source texel per beat in raster order (x, then rows, then
// slices); o_dst carries one averaged destination texel per beat, with
// last_of_level set on the final texel of the level. Both use valid/ready.
// The config port (i_cfg_we/i_cfg_idx/i_cfg_data) sets the source size and
// channel count; a write to one of its four registers restarts the level.
// Write only while idle. Throughput: one source beat per cycle while
// i_src.ready is high, set by one read-modify-write of the partial-sum
// memory per beat (read at accept, write in the next cycle, with a forwarding
// register for back-to-back beats on the same entry). A completed block's
// result goes from the sum stage registers into the output queue for o_dst.
// A 3-entry output queue holds results while o_dst stalls; i_src.ready drops
// only when the queue plus the beat in flight could overflow it.
// Reset clears position counters, queue and pipeline, and loads the
// registers with 1x1x1 and four channels. The sum memory needs no clearing:
// the first sample of each block writes its entry before any read.

module box_filter_mip_downsampler_core #(
    parameter int MAX_WIDTH    = bfmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bfmd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_DEPTH    = bfmd_pkg::DEF_MAX_DEPTH,
    parameter int MAX_CHANNELS = bfmd_pkg::DEF_MAX_CHANNELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bfmd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfmd_pkg::CFG_W-1:0]       i_cfg_data,
    bfmd_src_if.sink                         i_src,
    bfmd_dst_if.source                       o_dst
);
    localparam int XW          = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW          = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ZW          = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int STORE_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int BW          = $clog2(STORE_DEPTH + 1);
    localparam int STORE_W     = MAX_CHANNELS * bfmd_pkg::SUM_W;
    localparam int NC          = bfmd_pkg::NUM_CHAN;
    localparam int CH_W        = bfmd_pkg::CHAN_W;
    localparam int SW          = bfmd_pkg::SUM_W;

    // configuration
    logic [bfmd_pkg::CFG_W-1:0]    r_cfg_w;
    logic [bfmd_pkg::CFG_W-1:0]    r_cfg_h;
    logic [bfmd_pkg::CFG_W-1:0]    r_cfg_d;
    logic [bfmd_pkg::CH_CNT_W-1:0] r_cfg_ch;
    logic                          cfg_hit;
    logic [bfmd_pkg::CH_CNT_W-1:0] nch;
    logic [NC-1:0]                 lane_en;

    always_comb begin
        unique case (bfmd_pkg::t_cfg_reg'(i_cfg_idx))
            bfmd_pkg::CFG_SRC_WIDTH,
            bfmd_pkg::CFG_SRC_HEIGHT,
            bfmd_pkg::CFG_SRC_DEPTH,
            bfmd_pkg::CFG_CHANNELS: cfg_hit = i_cfg_we;
            default:                cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= bfmd_pkg::CFG_W'(1);
            r_cfg_h  <= bfmd_pkg::CFG_W'(1);
            r_cfg_d  <= bfmd_pkg::CFG_W'(1);
            r_cfg_ch <= bfmd_pkg::CH_CNT_W'(4);
        end else if (i_cfg_we) begin
            unique case (bfmd_pkg::t_cfg_reg'(i_cfg_idx))
                bfmd_pkg::CFG_SRC_WIDTH:  r_cfg_w  <= i_cfg_data;
                bfmd_pkg::CFG_SRC_HEIGHT: r_cfg_h  <= i_cfg_data;
                bfmd_pkg::CFG_SRC_DEPTH:  r_cfg_d  <= i_cfg_data;
                bfmd_pkg::CFG_CHANNELS:   r_cfg_ch <= i_cfg_data[bfmd_pkg::CH_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_ch == '0) begin
            nch = bfmd_pkg::CH_CNT_W'(1);
        end else if (r_cfg_ch > bfmd_pkg::CH_CNT_W'(MAX_CHANNELS)) begin
            nch = bfmd_pkg::CH_CNT_W'(MAX_CHANNELS);
        end else begin
            nch = r_cfg_ch;
        end
        for (int c = 0; c < NC; c++) begin
            lane_en[c] = (c < MAX_CHANNELS) && (bfmd_pkg::CH_CNT_W'(c) < nch);
        end
    end

    // position counters
    logic                  accept;
    logic                  step_y;
    logic                  step_z;
    logic [XW-1:0]         pos_x;
    logic [YW-1:0]         pos_y;
    logic [ZW-1:0]         pos_z;
    logic [XW:0]           half_x;
    logic [YW:0]           half_y;
    logic [ZW:0]           half_z;
    bfmd_pkg::t_axis_flags fx;
    bfmd_pkg::t_axis_flags fy;
    bfmd_pkg::t_axis_flags fz;

    assign accept = i_src.valid && i_src.ready;
    assign step_y = accept && fx.at_end;
    assign step_z = step_y && fy.at_end;

    bfmd_axis #(.MAX_SIZE(MAX_WIDTH)) u_axis_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_hit),
        .i_step     (accept),
        .i_cfg_size (r_cfg_w),
        .o_pos      (pos_x),
        .o_half     (half_x),
        .o_flags    (fx)
    );

    bfmd_axis #(.MAX_SIZE(MAX_HEIGHT)) u_axis_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_hit),
        .i_step     (step_y),
        .i_cfg_size (r_cfg_h),
        .o_pos      (pos_y),
        .o_half     (half_y),
        .o_flags    (fy)
    );

    bfmd_axis #(.MAX_SIZE(MAX_DEPTH)) u_axis_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_hit),
        .i_step     (step_z),
        .i_cfg_size (r_cfg_d),
        .o_pos      (pos_z),
        .o_half     (half_z),
        .o_flags    (fz)
    );

    // row base = (y/2) * dest width, kept as a running sum
    logic [BW-1:0] r_row_base;
    logic [BW-1:0] n_row_base;
    logic [BW-1:0] idx_full;
    logic [AW-1:0] rd_addr;
    logic          s0_in_range;
    logic          s0_first;
    logic          rd_en;

    always_comb begin
        n_row_base = r_row_base;
        if (cfg_hit) begin
            n_row_base = '0;
        end else if (step_y) begin
            if (fy.at_end) begin
                n_row_base = '0;
            end else if (pos_y[0]) begin
                n_row_base = r_row_base + BW'(half_x);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_base <= '0;
        end else begin
            r_row_base <= n_row_base;
        end
    end

    assign idx_full    = r_row_base + BW'(pos_x >> 1);
    assign rd_addr     = idx_full[AW-1:0];
    assign s0_in_range = fx.in_range && fy.in_range && fz.in_range;
    assign s0_first    = fx.even && fy.even && fz.even;
    assign rd_en       = accept && s0_in_range && !s0_first;

    // beat in flight: memory data arrives, sums are updated and written back
    logic                      r_s1_vld;
    logic                      r_s1_first;
    logic                      r_s1_res;
    logic                      r_s1_last;
    logic [1:0]                r_s1_shift;
    logic [AW-1:0]             r_s1_addr;
    logic [NC-1:0][CH_W-1:0]   r_s1_chan;
    logic [STORE_W-1:0]        r_rd_data;
    logic [STORE_W-1:0]        r_sum_mem [STORE_DEPTH];
    logic                      r_fwd_vld;
    logic [AW-1:0]             r_fwd_addr;
    logic [STORE_W-1:0]        r_fwd_data;
    logic [STORE_W-1:0]        old_packed;
    logic [STORE_W-1:0]        new_packed;
    bfmd_pkg::t_px_out         s1_px;
    logic                      s1_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_s1_vld  <= accept && s0_in_range;
            r_fwd_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_first   <= s0_first;
            r_s1_res     <= fx.last_smp && fy.last_smp && fz.last_smp;
            r_s1_last    <= fx.last_blk && fy.last_blk && fz.last_blk;
            r_s1_shift   <= 2'({1'b0, fx.multi} + {1'b0, fy.multi} + {1'b0, fz.multi});
            r_s1_addr    <= rd_addr;
            r_s1_chan[0] <= i_src.chan0_in;
            r_s1_chan[1] <= i_src.chan1_in;
            r_s1_chan[2] <= i_src.chan2_in;
            r_s1_chan[3] <= i_src.chan3_in;
        end
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= new_packed;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_sum_mem[r_s1_addr] <= new_packed;
        end
        if (rd_en) begin
            r_rd_data <= r_sum_mem[rd_addr];
        end
    end

    always_comb begin
        if (r_s1_first) begin
            old_packed = '0;
        end else if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            old_packed = r_fwd_data;
        end else begin
            old_packed = r_rd_data;
        end
    end

    for (genvar c = 0; c < NC; c++) begin : g_lane
        if (c < MAX_CHANNELS) begin : g_used
            logic [SW-1:0] lane_new;
            logic [SW-1:0] lane_avg;

            assign lane_new = lane_en[c] ? old_packed[c*SW +: SW] + SW'(r_s1_chan[c]) : '0;
            assign lane_avg = lane_new >> r_s1_shift;
            assign new_packed[c*SW +: SW] = lane_new;
            assign s1_px.chan[c] = lane_en[c] ? lane_avg[CH_W-1:0] : '0;
        end else begin : g_unused
            assign s1_px.chan[c] = '0;
        end
    end

    assign s1_px.last = r_s1_last;
    assign s1_push    = r_s1_vld && r_s1_res;

    // output queue
    bfmd_pkg::t_px_out               r_q [bfmd_pkg::OUTQ_DEPTH];
    logic [bfmd_pkg::QPTR_W-1:0]     r_q_wr;
    logic [bfmd_pkg::QPTR_W-1:0]     r_q_rd;
    logic [bfmd_pkg::QCNT_W-1:0]     r_q_cnt;
    logic                            q_pop;
    bfmd_pkg::t_px_out               q_head;

    assign q_pop  = o_dst.valid && o_dst.ready;
    assign q_head = r_q[r_q_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= '0;
            r_q_rd  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (s1_push) begin
                r_q_wr <= (r_q_wr == bfmd_pkg::QPTR_W'(bfmd_pkg::OUTQ_DEPTH - 1)) ?
                          '0 : r_q_wr + 1'b1;
            end
            if (q_pop) begin
                r_q_rd <= (r_q_rd == bfmd_pkg::QPTR_W'(bfmd_pkg::OUTQ_DEPTH - 1)) ?
                          '0 : r_q_rd + 1'b1;
            end
            r_q_cnt <= r_q_cnt + bfmd_pkg::QCNT_W'(s1_push) - bfmd_pkg::QCNT_W'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_push) begin
            r_q[r_q_wr] <= s1_px;
        end
    end

    assign i_src.ready = ({1'b0, r_q_cnt} + (bfmd_pkg::QCNT_W+1)'(s1_push))
                         <= (bfmd_pkg::QCNT_W+1)'(bfmd_pkg::OUTQ_DEPTH - 1);

    assign o_dst.valid         = r_q_cnt != '0;
    assign o_dst.chan0_out     = q_head.chan[0];
    assign o_dst.chan1_out     = q_head.chan[1];
    assign o_dst.chan2_out     = q_head.chan[2];
    assign o_dst.chan3_out     = q_head.chan[3];
    assign o_dst.last_of_level = q_head.last;

    logic unused_half;
    assign unused_half = ^{half_y, half_z, pos_z};

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bfmd_pkg::*;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] texel_t;

    localparam int STORE_DEPTH  = (DEF_MAX_WIDTH / 2) * (DEF_MAX_HEIGHT / 2);
    localparam int CFG_IDX_TOP  = 2 ** CFG_IDX_W - 1;
    localparam int RANDOM_TEXELS = 650;
    localparam int SETTLE_CYCLES = 5;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    bfmd_src_if src_if();
    bfmd_dst_if dst_if();

    box_filter_mip_downsampler_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_src      (src_if),
        .o_dst      (dst_if)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block: registers, raster position, partial sums
    logic [CFG_W-1:0]             width_reg = CFG_W'(1);
    logic [CFG_W-1:0]             height_reg = CFG_W'(1);
    logic [CFG_W-1:0]             depth_reg = CFG_W'(1);
    logic [CH_CNT_W-1:0]          chan_reg = CH_CNT_W'(4);
    int                           col_pos = 0;
    int                           row_pos = 0;
    int                           slice_pos = 0;
    logic [NUM_CHAN*SUM_W-1:0]    partial_sums [STORE_DEPTH];

    texel_t   texels_to_send [$];
    t_px_out  expected_dst_texels [$];
    t_px_out  dst_beat;
    t_px_out  want;
    int       errors = 0;
    int       texels_queued = 0;
    int       src_idle_pct = 0;
    int       dst_stall_pct = 0;

    function automatic int eff_size(input int v, input int maxv);
        return (v == 0) ? 1 : ((v > maxv) ? maxv : v);
    endfunction

    function automatic int half_size(input int v);
        return ((v >> 1) == 0) ? 1 : (v >> 1);
    endfunction

    function automatic int level_texels();
        return eff_size(width_reg, DEF_MAX_WIDTH) * eff_size(height_reg, DEF_MAX_HEIGHT) *
               eff_size(depth_reg, DEF_MAX_DEPTH);
    endfunction

    task automatic accumulate_texel(input texel_t px);
        int w, h, d, nch, dw, dh, dd, idx, div;
        logic [NUM_CHAN*SUM_W-1:0] sums;
        logic [SUM_W-1:0] s;
        t_px_out res;
        w   = eff_size(width_reg, DEF_MAX_WIDTH);
        h   = eff_size(height_reg, DEF_MAX_HEIGHT);
        d   = eff_size(depth_reg, DEF_MAX_DEPTH);
        nch = eff_size(chan_reg, DEF_MAX_CHANNELS);
        dw  = half_size(w);
        dh  = half_size(h);
        dd  = half_size(d);
        if (col_pos < 2 * dw && row_pos < 2 * dh && slice_pos < 2 * dd) begin
            idx  = (row_pos >> 1) * dw + (col_pos >> 1);
            sums = (((col_pos | row_pos | slice_pos) & 1) == 0) ? '0 : partial_sums[idx];
            for (int c = 0; c < NUM_CHAN; c++) begin
                s = sums[c*SUM_W +: SUM_W];
                s = (c < nch) ? SUM_W'(s + px[c]) : '0;
                sums[c*SUM_W +: SUM_W] = s;
            end
            partial_sums[idx] = sums;
            if ((w == 1 || (col_pos & 1)) && (h == 1 || (row_pos & 1)) &&
                (d == 1 || (slice_pos & 1))) begin
                div = ((w > 1) ? 2 : 1) * ((h > 1) ? 2 : 1) * ((d > 1) ? 2 : 1);
                for (int c = 0; c < NUM_CHAN; c++)
                    res.chan[c] = (c < nch) ? CHAN_W'(sums[c*SUM_W +: SUM_W] / div) : '0;
                res.last = ((col_pos >> 1) == dw - 1) && ((row_pos >> 1) == dh - 1) &&
                           ((slice_pos >> 1) == dd - 1);
                expected_dst_texels.push_back(res);
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
                slice_pos++;
                if (slice_pos >= d)
                    slice_pos = 0;
            end
        end
    endtask

    // source beat driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_if.valid <= 1'b0;
        end else begin
            if (src_if.valid && src_if.ready)
                accumulate_texel({src_if.chan3_in, src_if.chan2_in,
                                  src_if.chan1_in, src_if.chan0_in});
            if (!src_if.valid || src_if.ready) begin
                if (texels_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    {src_if.chan3_in, src_if.chan2_in, src_if.chan1_in, src_if.chan0_in}
                        <= texels_to_send.pop_front();
                    src_if.valid <= 1'b1;
                end else begin
                    src_if.valid <= 1'b0;
                end
            end
        end
    end

    // destination beat monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dst_if.ready <= 1'b0;
        end else begin
            if (dst_if.valid && dst_if.ready) begin
                dst_beat = {dst_if.chan3_out, dst_if.chan2_out, dst_if.chan1_out,
                            dst_if.chan0_out, dst_if.last_of_level};
                if (expected_dst_texels.size() == 0) begin
                    $error("o_dst beat with no texel expected");
                    errors++;
                end else begin
                    want = expected_dst_texels.pop_front();
                    for (int c = 0; c < NUM_CHAN; c++) begin
                        if (dst_beat.chan[c] !== want.chan[c]) begin
                            $error("chan%0d_out: expected %0d, got %0d",
                                   c, want.chan[c], dst_beat.chan[c]);
                            errors++;
                        end
                    end
                    if (dst_beat.last !== want.last) begin
                        $error("last_of_level: expected %0d, got %0d", want.last, dst_beat.last);
                        errors++;
                    end
                end
            end
            dst_if.ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SRC_WIDTH:  width_reg = data;
            CFG_SRC_HEIGHT: height_reg = data;
            CFG_SRC_DEPTH:  depth_reg = data;
            CFG_CHANNELS:   chan_reg = data[CH_CNT_W-1:0];
            default: ;
        endcase
        if (idx <= CFG_CHANNELS) begin
            col_pos   = 0;
            row_pos   = 0;
            slice_pos = 0;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_level(input int w, input int h, input int d, input int ch);
        write_reg(CFG_SRC_WIDTH, CFG_W'(w));
        write_reg(CFG_SRC_HEIGHT, CFG_W'(h));
        write_reg(CFG_SRC_DEPTH, CFG_W'(d));
        write_reg(CFG_CHANNELS, CFG_W'(ch));
    endtask

    task automatic push_texels(input int n, input bit saturated);
        texel_t px;
        repeat (n) begin
            px = $urandom();
            if (saturated)
                for (int c = 0; c < NUM_CHAN; c++)
                    px[c] = $urandom_range(1) ? 8'hFF : 8'h00;
            texels_to_send.push_back(px);
            texels_queued++;
        end
    endtask

    task automatic wait_idle();
        while (texels_to_send.size() != 0 || src_if.valid || expected_dst_texels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
            1: begin src_idle_pct = 73; dst_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  dst_stall_pct = 73; end
            default: begin src_idle_pct = 27; dst_stall_pct = 27; end
        endcase
    endtask

    initial begin
        int rand_start, level, n, mode, half, w, h, d, long_val;
        bit saturated;
        src_if.valid    = 1'b0;
        src_if.chan0_in = '0;
        src_if.chan1_in = '0;
        src_if.chan2_in = '0;
        src_if.chan3_in = '0;
        dst_if.ready    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: 1x1x1, every texel passes through
        texels_to_send.push_back('0);
        texels_to_send.push_back('1);
        texels_queued += 2;
        wait_idle();
        // full 2x2x2 block at maximum sums
        program_level(2, 2, 2, 4);
        repeat (8) texels_to_send.push_back('1);
        texels_queued += 8;
        wait_idle();
        // odd trailing column, two channels
        program_level(3, 1, 1, 2);
        push_texels(3, 0);
        wait_idle();
        // zero sizes and zero channels act as 1; odd trailing row
        program_level(0, 3, 0, 0);
        push_texels(3, 0);
        wait_idle();
        // channel count above max; unused index must not restart the level; wrap
        program_level(2, 2, 1, 5);
        push_texels(2, 0);
        wait_idle();
        write_reg(CFG_IDX_W'(CFG_IDX_TOP), CFG_W'($urandom_range(511)));
        push_texels(6, 0);
        wait_idle();

        rand_start = texels_queued;
        level = 0;
        while (texels_queued - rand_start < RANDOM_TEXELS) begin
            level++;
            set_idling((level / 5) % 4);
            mode = $urandom_range(9);
            if (level % 12 == 3) begin
                case ($urandom_range(2))
                    0: long_val = 255;
                    1: long_val = 256;
                    default: long_val = 511;
                endcase
                w = 1;
                h = 1;
                d = 1;
                case ((level / 12) % 3)
                    0: w = long_val;
                    1: h = long_val;
                    default: d = long_val;
                endcase
                if ((level / 12) % 3 == 0)
                    mode = 9;
                else
                    mode = 0;
            end else begin
                w = $urandom_range(6);
                h = $urandom_range(6);
                d = $urandom_range(4);
            end
            program_level(w, h, d, $urandom_range(511));
            n = level_texels();
            saturated = ($urandom_range(9) == 0);
            case (mode)
                0: push_texels($urandom_range((n > 120) ? 120 : n, 1), saturated);
                1: begin
                    // pause mid-level until all results are out
                    half = n / 2;
                    push_texels(half, saturated);
                    wait_idle();
                    if ($urandom_range(1))
                        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_TOP,
                                                            int'(CFG_CHANNELS) + 1)),
                                  CFG_W'($urandom_range(511)));
                    push_texels(n - half, saturated);
                end
                2: push_texels(2 * n, saturated);
                default: push_texels(n, saturated);
            endcase
            wait_idle();
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("box_filter_mip_downsampler_core regression: pass");
        else
            $display("box_filter_mip_downsampler_core regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("box_filter_mip_downsampler_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/bfmd_pkg.sv
hw/rtl/bfmd_src_if.sv
hw/rtl/bfmd_dst_if.sv
hw/rtl/bfmd_axis.sv
hw/rtl/box_filter_mip_downsampler_core.sv
verif/testbench.sv
